// ===== rtl/srtg_pkg.sv =====
// ----------------------------------------------------------------------------
// srtg_pkg
// Types and constants shared by the segment rate timeline gap counter.
// ----------------------------------------------------------------------------
`default_nettype none

package srtg_pkg;

   localparam int MAX_TRACKS  = 8;
   localparam int MAX_ENTRIES = 64;
   localparam int TRK_W       = $clog2(MAX_TRACKS);
   localparam int NTRK_W      = TRK_W + 1;
   localparam int ENT_W       = $clog2(MAX_ENTRIES);
   localparam int CNT_W       = ENT_W + 1;
   localparam int ADDR_W      = TRK_W + ENT_W;
   localparam int VAL_W       = 32;
   localparam int CFG_W       = 4;

   localparam logic [VAL_W-1:0] NO_RATE  = '1;
   localparam logic [VAL_W-1:0] ALL_ONES = '1;

   typedef enum logic [2:0] {
      KIND_CLEAR  = 3'd0,
      KIND_APPEND = 3'd1,
      KIND_REWIND = 3'd2,
      KIND_LOOKUP = 3'd3,
      KIND_GAP    = 3'd4
   } kind_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ADV_RD,
      ST_ADV_EV,
      ST_GAP_RD,
      ST_GAP_EV,
      ST_GAP_ADD,
      ST_GAP_END,
      ST_SCAN_TRK,
      ST_SCAN_RD,
      ST_SCAN_EV,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic [VAL_W-1:0] a;
      logic [VAL_W-1:0] b;
   } alu_req_type;

   typedef struct packed {
      logic [VAL_W-1:0] diff;
      logic             borrow;
      logic             zero;
   } alu_rsp_type;

endpackage

`default_nettype wire

// ===== rtl/srtg_ram.sv =====
// ----------------------------------------------------------------------------
// srtg_ram
// Generic simple dual port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module srtg_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 512
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

// ===== rtl/srtg_alu.sv =====
// ----------------------------------------------------------------------------
// srtg_alu
// Shared subtract and compare unit used by the sequencer's walk and gap steps.
// ----------------------------------------------------------------------------
`default_nettype none

module srtg_alu
   import srtg_pkg::*;
(
   input  wire alu_req_type alu_req,
   output alu_rsp_type      alu_rsp
);

   logic [VAL_W:0] full_diff;

   assign full_diff      = {1'b0, alu_req.a} - {1'b0, alu_req.b};
   assign alu_rsp.diff   = full_diff[VAL_W-1:0];
   assign alu_rsp.borrow = full_diff[VAL_W];
   assign alu_rsp.zero   = (full_diff[VAL_W-1:0] == '0);

endmodule

`default_nettype wire

// ===== rtl/srtg_seq.sv =====
// ----------------------------------------------------------------------------
// srtg_seq
// Command sequencer: per-track counts, cursors and held rates, entry walks,
// gap accumulation, remaining-rate scan and result delivery.
// ----------------------------------------------------------------------------
`default_nettype none

module srtg_seq
   import srtg_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic [NTRK_W-1:0] n_active,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic [2:0]        req_kind,
   input  wire logic [TRK_W-1:0]  req_track_sel,
   input  wire logic [VAL_W-1:0]  req_seg_index,
   input  wire logic [VAL_W-1:0]  req_end_index,
   input  wire logic [VAL_W-1:0]  req_rate_value,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output logic [TRK_W-1:0]       rsp_track_out,
   output logic [VAL_W-1:0]       rsp_rate_out,
   output logic [VAL_W-1:0]       rsp_gaps_out,
   output logic                   rsp_any_rate,
   output logic                   rsp_full_error,
   output logic                   rsp_last_out,
   output logic                   ram_wr_en,
   output logic [ADDR_W-1:0]      ram_wr_addr,
   output logic [2*VAL_W-1:0]     ram_wr_data,
   output logic [ADDR_W-1:0]      ram_rd_addr,
   input  wire logic [2*VAL_W-1:0] ram_rd_data,
   output alu_req_type            alu_req,
   input  wire alu_rsp_type       alu_rsp
);

   state_type         state_ff, state_in;
   kind_type          cmd_ff, cmd_in;
   logic [CNT_W-1:0]  count_ff [MAX_TRACKS];
   logic [CNT_W-1:0]  count_in [MAX_TRACKS];
   logic [CNT_W-1:0]  cursor_ff [MAX_TRACKS];
   logic [CNT_W-1:0]  cursor_in [MAX_TRACKS];
   logic [VAL_W-1:0]  held_ff [MAX_TRACKS];
   logic [VAL_W-1:0]  held_in [MAX_TRACKS];
   logic [NTRK_W-1:0] trk_ff, trk_in;
   logic [CNT_W-1:0]  ent_ff, ent_in;
   logic [VAL_W-1:0]  seg_ff, seg_in;
   logic [VAL_W-1:0]  end_ff, end_in;
   logic [VAL_W-1:0]  start_ff, start_in;
   logic [VAL_W-1:0]  sum_ff, sum_in;
   logic [VAL_W-1:0]  best_ff, best_in;
   logic              flag_ff, flag_in;
   logic              err_ff, err_in;
   logic [ADDR_W-1:0] rd_addr_ff, rd_addr_in;

   logic [TRK_W-1:0]  sel;
   logic [CNT_W-1:0]  sel_count;
   logic [CNT_W-1:0]  sel_cursor;
   logic [VAL_W-1:0]  sel_held;
   logic              cur_end;
   logic              last_trk;
   logic              req_fire;
   logic              rsp_fire;
   logic [VAL_W-1:0]  e_start;
   logic [VAL_W-1:0]  e_rate;
   logic              alu_gt;
   logic [VAL_W:0]    sum_wide;
   logic [VAL_W-1:0]  sum_sat;
   logic [VAL_W-1:0]  sum_next;

   // one index for all per-track tables
   assign sel        = (state_ff == ST_IDLE) ? req_track_sel : trk_ff[TRK_W-1:0];
   assign sel_count  = count_ff[sel];
   assign sel_cursor = cursor_ff[sel];
   assign sel_held   = held_ff[sel];
   assign cur_end    = (sel_cursor >= sel_count);
   assign last_trk   = ((trk_ff + NTRK_W'(1)) == n_active);
   assign req_fire   = req_valid && req_ready;
   assign rsp_fire   = rsp_valid && rsp_ready;
   assign e_start    = ram_rd_data[VAL_W-1:0];
   assign e_rate     = ram_rd_data[2*VAL_W-1:VAL_W];
   assign alu_gt     = !alu_rsp.borrow && !alu_rsp.zero;
   assign sum_wide   = {1'b0, sum_ff} + {1'b0, alu_rsp.diff};
   assign sum_sat    = sum_wide[VAL_W] ? ALL_ONES : sum_wide[VAL_W-1:0];
   assign sum_next   = ((sel_held == '0) && alu_gt) ? sum_sat : sum_ff;
   assign ram_rd_addr = rd_addr_in;

   always_comb begin : next_state
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if ((req_kind == KIND_LOOKUP) || (req_kind == KIND_GAP)) begin
                  state_in = ST_ADV_RD;
               end else begin
                  state_in = ST_SCAN_TRK;
               end
            end
         end
         ST_ADV_RD: begin
            if (!cur_end) begin
               state_in = ST_ADV_EV;
            end else if (cmd_ff == KIND_GAP) begin
               state_in = ST_GAP_RD;
            end else if (last_trk) begin
               state_in = ST_SCAN_TRK;
            end
         end
         ST_ADV_EV: begin
            if (!alu_rsp.borrow) begin
               state_in = ST_ADV_RD;
            end else if (cmd_ff == KIND_GAP) begin
               state_in = ST_GAP_RD;
            end else if (last_trk) begin
               state_in = ST_SCAN_TRK;
            end else begin
               state_in = ST_ADV_RD;
            end
         end
         ST_GAP_RD: begin
            state_in = cur_end ? ST_GAP_END : ST_GAP_EV;
         end
         ST_GAP_EV: begin
            state_in = alu_rsp.borrow ? ST_GAP_ADD : ST_GAP_END;
         end
         ST_GAP_ADD: begin
            state_in = ST_GAP_RD;
         end
         ST_GAP_END: begin
            state_in = last_trk ? ST_SCAN_TRK : ST_ADV_RD;
         end
         ST_SCAN_TRK: begin
            state_in = (trk_ff == n_active) ? ST_EMIT : ST_SCAN_RD;
         end
         ST_SCAN_RD: begin
            state_in = (ent_ff >= sel_count) ? ST_SCAN_TRK : ST_SCAN_EV;
         end
         ST_SCAN_EV: begin
            if ((e_rate != '0) && (e_rate != NO_RATE)) begin
               state_in = ST_EMIT;
            end else begin
               state_in = ST_SCAN_RD;
            end
         end
         ST_EMIT: begin
            if (rsp_ready && ((cmd_ff != KIND_LOOKUP) || last_trk)) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin : datapath
      cmd_in     = cmd_ff;
      count_in   = count_ff;
      cursor_in  = cursor_ff;
      held_in    = held_ff;
      trk_in     = trk_ff;
      ent_in     = ent_ff;
      seg_in     = seg_ff;
      end_in     = end_ff;
      start_in   = start_ff;
      sum_in     = sum_ff;
      best_in    = best_ff;
      flag_in    = flag_ff;
      err_in     = err_ff;
      rd_addr_in = rd_addr_ff;
      ram_wr_en   = 1'b0;
      ram_wr_addr = {sel, sel_count[ENT_W-1:0]};
      ram_wr_data = {req_rate_value, req_seg_index};
      alu_req.a   = '0;
      alu_req.b   = '0;
      req_ready   = (state_ff == ST_IDLE);
      rsp_valid   = (state_ff == ST_EMIT);
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd_in  = kind_type'(req_kind);
               seg_in  = req_seg_index;
               end_in  = req_end_index;
               trk_in  = '0;
               best_in = ALL_ONES;
               err_in  = 1'b0;
               flag_in = 1'b0;
               case (req_kind)
                  KIND_CLEAR: begin
                     for (int t = 0; t < MAX_TRACKS; t++) begin
                        count_in[t]  = '0;
                        cursor_in[t] = '0;
                        held_in[t]   = NO_RATE;
                     end
                  end
                  KIND_REWIND: begin
                     for (int t = 0; t < MAX_TRACKS; t++) begin
                        cursor_in[t] = '0;
                        held_in[t]   = NO_RATE;
                     end
                  end
                  KIND_APPEND: begin
                     if (sel_count == CNT_W'(MAX_ENTRIES)) begin
                        err_in = 1'b1;
                     end else begin
                        ram_wr_en       = 1'b1;
                        count_in[sel]   = sel_count + CNT_W'(1);
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_ADV_RD: begin
            rd_addr_in = {sel, sel_cursor[ENT_W-1:0]};
            if (cur_end) begin
               if (cmd_ff == KIND_GAP) begin
                  sum_in   = '0;
                  start_in = seg_ff;
               end else begin
                  trk_in = last_trk ? '0 : trk_ff + NTRK_W'(1);
               end
            end
         end
         ST_ADV_EV: begin
            alu_req.a = seg_ff;
            alu_req.b = e_start;
            if (!alu_rsp.borrow) begin
               held_in[sel]   = e_rate;
               cursor_in[sel] = sel_cursor + CNT_W'(1);
            end else if (cmd_ff == KIND_GAP) begin
               sum_in   = '0;
               start_in = seg_ff;
            end else begin
               trk_in = last_trk ? '0 : trk_ff + NTRK_W'(1);
            end
         end
         ST_GAP_RD: begin
            rd_addr_in = {sel, sel_cursor[ENT_W-1:0]};
         end
         ST_GAP_EV: begin
            // entry at or beyond the range end closes the walk
            alu_req.a = e_start;
            alu_req.b = end_ff;
         end
         ST_GAP_ADD: begin
            alu_req.a      = e_start;
            alu_req.b      = start_ff;
            sum_in         = sum_next;
            held_in[sel]   = e_rate;
            start_in       = e_start;
            cursor_in[sel] = sel_cursor + CNT_W'(1);
         end
         ST_GAP_END: begin
            alu_req.a = end_ff;
            alu_req.b = start_ff;
            if (sum_next < best_ff) begin
               best_in = sum_next;
            end
            trk_in = last_trk ? '0 : trk_ff + NTRK_W'(1);
         end
         ST_SCAN_TRK: begin
            if (trk_ff == n_active) begin
               trk_in = '0;
            end else begin
               ent_in = sel_cursor;
            end
         end
         ST_SCAN_RD: begin
            rd_addr_in = {sel, ent_ff[ENT_W-1:0]};
            if (ent_ff >= sel_count) begin
               trk_in = trk_ff + NTRK_W'(1);
            end
         end
         ST_SCAN_EV: begin
            if ((e_rate != '0) && (e_rate != NO_RATE)) begin
               flag_in = 1'b1;
               trk_in  = '0;
            end else begin
               ent_in = ent_ff + CNT_W'(1);
            end
         end
         ST_EMIT: begin
            if (rsp_ready && (cmd_ff == KIND_LOOKUP) && !last_trk) begin
               trk_in = trk_ff + NTRK_W'(1);
            end
         end
         default: begin
         end
      endcase
   end

   assign rsp_track_out  = (cmd_ff == KIND_LOOKUP) ? trk_ff[TRK_W-1:0] : '0;
   assign rsp_rate_out   = (cmd_ff == KIND_LOOKUP) ? sel_held : '0;
   assign rsp_gaps_out   = (cmd_ff == KIND_GAP) ? best_ff : '0;
   assign rsp_any_rate   = flag_ff;
   assign rsp_full_error = err_ff;
   assign rsp_last_out   = (cmd_ff == KIND_LOOKUP) ? last_trk : 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         for (int t = 0; t < MAX_TRACKS; t++) begin
            count_ff[t]  <= '0;
            cursor_ff[t] <= '0;
            held_ff[t]   <= NO_RATE;
         end
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         cursor_ff <= cursor_in;
         held_ff   <= held_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff     <= cmd_in;
      trk_ff     <= trk_in;
      ent_ff     <= ent_in;
      seg_ff     <= seg_in;
      end_ff     <= end_in;
      start_ff   <= start_in;
      sum_ff     <= sum_in;
      best_ff    <= best_in;
      flag_ff    <= flag_in;
      err_ff     <= err_in;
      rd_addr_ff <= rd_addr_in;
   end

`ifndef SYNTH
   a_cursor_in_list: assert property (@(posedge clock) disable iff (reset)
      cursor_ff[sel] <= count_ff[sel])
      else $error("cursor passed the end of its entry list");

   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_ready)
      else $error("ready while a command is in progress");

   a_idle_after_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_fire && rsp_last_out) |=> req_ready)
      else $error("not idle after the final result transfer");

   a_count_limit: assert property (@(posedge clock) disable iff (reset)
      count_ff[sel] <= CNT_W'(MAX_ENTRIES))
      else $error("entry count above list capacity");
`endif

endmodule

`default_nettype wire

// ===== rtl/segment_rate_timeline_gap_counter_top.sv =====
// ----------------------------------------------------------------------------
// segment_rate_timeline_gap_counter_top
// Per-track rate timelines with lookup and zero-rate gap counting.
// ----------------------------------------------------------------------------
// channel  dir  handshake               payload
// req      in   req_tvalid/req_tready   tdata: track_sel, seg_index, end_index,
//                                       rate_value; tuser: kind
// rsp      out  rsp_tvalid/rsp_tready   tdata: track_out, rate_out, gaps_out;
//                                       tuser: any_rate, full_error; tlast
// csr      in   csr_valid/csr_ready     csr_data: tracks_in_use
//
// one command at a time; the entry store read port sets the pace: each entry
// passed or scanned takes a read and an evaluate state, and each entry crossed
// by a gap walk adds an accumulate state. lookup and gap walk entries from
// each cursor; afterwards every command scans the entries not yet passed for
// a real rate.
// reset clears counts, cursors and held rates at once; no clearing pass.
// results wait in place while rsp_tready is low.
// ----------------------------------------------------------------------------
`default_nettype none

module segment_rate_timeline_gap_counter_top
   import srtg_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_tvalid,
   output logic                  req_tready,
   input  wire logic [103:0]     req_tdata,  // track_sel, seg_index, end_index, rate_value
   input  wire logic [2:0]       req_tuser,  // kind
   output logic                  rsp_tvalid,
   input  wire logic             rsp_tready,
   output logic [71:0]           rsp_tdata,  // track_out, rate_out, gaps_out
   output logic [1:0]            rsp_tuser,  // any_rate, full_error
   output logic                  rsp_tlast,
   input  wire logic             csr_valid,
   output logic                  csr_ready,
   input  wire logic [CFG_W-1:0] csr_data
);

   logic [CFG_W-1:0]   tracks_ff;
   logic [NTRK_W-1:0]  n_active;
   logic               ram_wr_en;
   logic [ADDR_W-1:0]  ram_wr_addr;
   logic [2*VAL_W-1:0] ram_wr_data;
   logic [ADDR_W-1:0]  ram_rd_addr;
   logic [2*VAL_W-1:0] ram_rd_data;
   alu_req_type        alu_req;
   alu_rsp_type        alu_rsp;
   logic [TRK_W-1:0]   track_out;
   logic [VAL_W-1:0]   rate_out;
   logic [VAL_W-1:0]   gaps_out;
   logic               any_rate;
   logic               full_error;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         tracks_ff <= CFG_W'(1);
      end else if (csr_valid && csr_ready) begin
         tracks_ff <= csr_data;
      end
   end

   // zero acts as one, above capacity acts as capacity
   always_comb begin
      if (tracks_ff == '0) begin
         n_active = NTRK_W'(1);
      end else if (tracks_ff > CFG_W'(MAX_TRACKS)) begin
         n_active = NTRK_W'(MAX_TRACKS);
      end else begin
         n_active = NTRK_W'(tracks_ff);
      end
   end

   srtg_seq u_seq (
      .clock          (clock),
      .reset          (reset),
      .n_active       (n_active),
      .req_valid      (req_tvalid),
      .req_ready      (req_tready),
      .req_kind       (req_tuser),
      .req_track_sel  (req_tdata[2:0]),
      .req_seg_index  (req_tdata[34:3]),
      .req_end_index  (req_tdata[66:35]),
      .req_rate_value (req_tdata[98:67]),
      .rsp_valid      (rsp_tvalid),
      .rsp_ready      (rsp_tready),
      .rsp_track_out  (track_out),
      .rsp_rate_out   (rate_out),
      .rsp_gaps_out   (gaps_out),
      .rsp_any_rate   (any_rate),
      .rsp_full_error (full_error),
      .rsp_last_out   (rsp_tlast),
      .ram_wr_en      (ram_wr_en),
      .ram_wr_addr    (ram_wr_addr),
      .ram_wr_data    (ram_wr_data),
      .ram_rd_addr    (ram_rd_addr),
      .ram_rd_data    (ram_rd_data),
      .alu_req        (alu_req),
      .alu_rsp        (alu_rsp)
   );

   srtg_alu u_alu (
      .alu_req (alu_req),
      .alu_rsp (alu_rsp)
   );

   srtg_ram #(
      .WIDTH (2*VAL_W),
      .DEPTH (MAX_TRACKS*MAX_ENTRIES)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign rsp_tdata = {5'b0, gaps_out, rate_out, track_out};
   assign rsp_tuser = {full_error, any_rate};

endmodule

`default_nettype wire
